// File: src/nffa_pkg.sv
package nffa_pkg;

  localparam int NUM_FRAMES = 4096;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int SPAN_W     = FRAME_W + 1;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_ROWS   = NUM_FRAMES / WORD_W;
  localparam int ROW_W      = $clog2(NUM_ROWS);
  localparam int MAX_RUN    = 64;
  localparam int CNT_W      = 7;
  localparam int STEP_W     = 5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 12;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [SPAN_W-1:0]  span_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [BIT_W-1:0]   bitpos_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [STEP_W-1:0]  step_t;

  localparam frame_t FRAME_MAX   = frame_t'(NUM_FRAMES - 1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'hFFF;
  localparam logic REG_FRAME_LIMIT = 1'b0;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_OOM      = 1'b1;

  typedef enum logic [3:0] {
    A_NOP,
    A_CLR,
    A_IDLE,
    A_SETUP1,
    A_SETUP2,
    A_FETCH,
    A_TEST,
    A_RANGE_ALLOC,
    A_RANGE_REL,
    A_RD_A,
    A_WR_A,
    A_RD_E,
    A_WR_E,
    A_OUT_OK,
    A_OUT_FAIL
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_MORE,
    C_NO_ITEM,
    C_BAD_COUNT,
    C_RELEASE,
    C_EMPTY1,
    C_EMPTY2,
    C_FOUND_NOW,
    C_CONTINUE,
    C_PAST_END,
    C_PASS2,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
  } ucw_t;

  typedef struct packed {
    logic clr_more;
    logic no_item;
    logic bad_count;
    logic is_release;
    logic empty1;
    logic empty2;
    logic found_now;
    logic cont;
    logic past_end;
    logic pass2;
    logic out_busy;
  } flags_t;

  localparam step_t S_CLR     = 5'd0;
  localparam step_t S_IDLE    = 5'd1;
  localparam step_t S_CHECK   = 5'd2;
  localparam step_t S_SETUP1  = 5'd3;
  localparam step_t S_FETCH   = 5'd4;
  localparam step_t S_TEST    = 5'd5;
  localparam step_t S_STEP    = 5'd6;
  localparam step_t S_NEXT    = 5'd7;
  localparam step_t S_SETUP2  = 5'd8;
  localparam step_t S_MARK    = 5'd9;
  localparam step_t S_REL     = 5'd10;
  localparam step_t S_RD_A    = 5'd11;
  localparam step_t S_WR_A    = 5'd12;
  localparam step_t S_RD_E    = 5'd13;
  localparam step_t S_WR_E    = 5'd14;
  localparam step_t S_DONE    = 5'd15;
  localparam step_t S_OK      = 5'd16;
  localparam step_t S_FAIL    = 5'd17;
  localparam step_t S_FAILOUT = 5'd18;

  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = '{A_NOP, C_ALWAYS, S_IDLE, C_NEVER, S_IDLE};
    unique case (s)
      S_CLR:     w = '{A_CLR,         C_CLR_MORE,  S_CLR,    C_NEVER,    S_CLR};
      S_IDLE:    w = '{A_IDLE,        C_NO_ITEM,   S_IDLE,   C_NEVER,    S_IDLE};
      S_CHECK:   w = '{A_NOP,         C_BAD_COUNT, S_FAIL,   C_RELEASE,  S_REL};
      S_SETUP1:  w = '{A_SETUP1,      C_EMPTY1,    S_NEXT,   C_NEVER,    S_IDLE};
      S_FETCH:   w = '{A_FETCH,       C_NEVER,     S_IDLE,   C_NEVER,    S_IDLE};
      S_TEST:    w = '{A_TEST,        C_FOUND_NOW, S_MARK,   C_CONTINUE, S_TEST};
      S_STEP:    w = '{A_NOP,         C_PAST_END,  S_NEXT,   C_ALWAYS,   S_FETCH};
      S_NEXT:    w = '{A_NOP,         C_PASS2,     S_FAIL,   C_NEVER,    S_IDLE};
      S_SETUP2:  w = '{A_SETUP2,      C_EMPTY2,    S_FAIL,   C_ALWAYS,   S_FETCH};
      S_MARK:    w = '{A_RANGE_ALLOC, C_ALWAYS,    S_RD_A,   C_NEVER,    S_IDLE};
      S_REL:     w = '{A_RANGE_REL,   C_NEVER,     S_IDLE,   C_NEVER,    S_IDLE};
      S_RD_A:    w = '{A_RD_A,        C_NEVER,     S_IDLE,   C_NEVER,    S_IDLE};
      S_WR_A:    w = '{A_WR_A,        C_NEVER,     S_IDLE,   C_NEVER,    S_IDLE};
      S_RD_E:    w = '{A_RD_E,        C_NEVER,     S_IDLE,   C_NEVER,    S_IDLE};
      S_WR_E:    w = '{A_WR_E,        C_NEVER,     S_IDLE,   C_NEVER,    S_IDLE};
      S_DONE:    w = '{A_NOP,         C_OUT_BUSY,  S_DONE,   C_NEVER,    S_IDLE};
      S_OK:      w = '{A_OUT_OK,      C_ALWAYS,    S_IDLE,   C_NEVER,    S_IDLE};
      S_FAIL:    w = '{A_NOP,         C_OUT_BUSY,  S_FAIL,   C_NEVER,    S_IDLE};
      S_FAILOUT: w = '{A_OUT_FAIL,    C_ALWAYS,    S_IDLE,   C_NEVER,    S_IDLE};
      default:   w = '{A_NOP,         C_ALWAYS,    S_IDLE,   C_NEVER,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: src/nffa_seq.sv
module nffa_seq
  import nffa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output act_t   act
);

  step_t step_r, step_nxt;
  ucw_t  ucw;
  logic  take_a, take_b;

  function automatic logic cond_true(cond_t c, flags_t f);
    logic t;
    t = 1'b0;
    case (c)
      C_NEVER:     t = 1'b0;
      C_ALWAYS:    t = 1'b1;
      C_CLR_MORE:  t = f.clr_more;
      C_NO_ITEM:   t = f.no_item;
      C_BAD_COUNT: t = f.bad_count;
      C_RELEASE:   t = f.is_release;
      C_EMPTY1:    t = f.empty1;
      C_EMPTY2:    t = f.empty2;
      C_FOUND_NOW: t = f.found_now;
      C_CONTINUE:  t = f.cont;
      C_PAST_END:  t = f.past_end;
      C_PASS2:     t = f.pass2;
      C_OUT_BUSY:  t = f.out_busy;
      default:     t = 1'b0;
    endcase
    return t;
  endfunction

  always_comb begin
    ucw    = ucode(step_r);
    take_a = cond_true(ucw.cond_a, flags);
    take_b = cond_true(ucw.cond_b, flags);
    if (take_a) begin
      step_nxt = ucw.tgt_a;
    end else if (take_b) begin
      step_nxt = ucw.tgt_b;
    end else begin
      step_nxt = step_t'(step_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign act = ucw.act;

endmodule

// File: src/nffa_dp.sv
module nffa_dp
  import nffa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  act_t         act,
  output flags_t       flags,
  input  frame_t       frame_limit,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_command,
  input  cnt_t         in_frame_count,
  input  frame_t       in_start_frame,
  output logic         out_valid,
  input  logic         out_stall,
  output frame_t       out_first_frame,
  output logic         out_status
);

  word_t   mem [NUM_ROWS];
  word_t   rdata_r;

  logic    cmd_r;
  cnt_t    cnt_r;
  frame_t  sf_r;
  frame_t  last_look_r;
  frame_t  start_r;
  frame_t  a_r;
  frame_t  e_r;
  span_t   f_r;
  span_t   end_r;
  cnt_t    run_r;
  logic    pass_r;
  logic    val_r;
  logic    out_valid_r;
  logic    out_status_r;
  frame_t  out_first_r;

  frame_t  lo1;
  span_t   cm1;
  span_t   lim_s;
  span_t   sum1;
  span_t   sum2;
  span_t   end1;
  span_t   end2;
  span_t   rel_sum;
  frame_t  rel_e;
  frame_t  alloc_e;
  frame_t  start_cand;
  logic    bit_now;
  cnt_t    run_inc;
  logic    found_now;
  row_t    a_row;
  row_t    e_row;
  row_t    wrow;
  bitpos_t lo_b;
  bitpos_t hi_b;
  word_t   ones;
  word_t   mask;
  logic    mem_we;
  logic    mem_re;
  row_t    waddr;
  row_t    raddr;
  word_t   wdata;

  always_comb begin
    lo1        = (last_look_r == '0) ? frame_t'(1) : last_look_r;
    cm1        = span_t'(cnt_r) - span_t'(1);
    lim_s      = span_t'(frame_limit);
    sum1       = lim_s + cm1;
    end1       = (sum1 > lim_s) ? lim_s : sum1;
    sum2       = span_t'(last_look_r) + cm1;
    end2       = (sum2 > lim_s) ? lim_s : sum2;
    rel_sum    = span_t'(sf_r) + cm1;
    rel_e      = (rel_sum > span_t'(FRAME_MAX)) ? FRAME_MAX : rel_sum[FRAME_W-1:0];
    alloc_e    = start_r + cm1[FRAME_W-1:0];
    start_cand = f_r[FRAME_W-1:0] - cm1[FRAME_W-1:0];
    bit_now    = rdata_r[f_r[BIT_W-1:0]];
    run_inc    = cnt_t'(run_r + 1'b1);
    found_now  = !bit_now && (run_inc == cnt_r);

    a_row = a_r[FRAME_W-1:BIT_W];
    e_row = e_r[FRAME_W-1:BIT_W];
    wrow  = (act == A_WR_E) ? e_row : a_row;
    lo_b  = (wrow == a_row) ? a_r[BIT_W-1:0] : '0;
    hi_b  = (wrow == e_row) ? e_r[BIT_W-1:0] : '1;
    ones  = '1;
    mask  = (ones << lo_b) & (ones >> (~hi_b));
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = wrow;
    raddr  = a_row;
    wdata  = val_r ? (rdata_r | mask) : (rdata_r & ~mask);
    unique case (act)
      A_CLR: begin
        mem_we = 1'b1;
        waddr  = f_r[ROW_W-1:0];
        wdata  = '0;
      end
      A_WR_A, A_WR_E: begin
        mem_we = 1'b1;
      end
      A_FETCH: begin
        mem_re = 1'b1;
        raddr  = f_r[FRAME_W-1:BIT_W];
      end
      A_RD_A: begin
        mem_re = 1'b1;
        raddr  = a_row;
      end
      A_RD_E: begin
        mem_re = 1'b1;
        raddr  = e_row;
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r         <= '0;
      last_look_r <= frame_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (act == A_OUT_OK || act == A_OUT_FAIL) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (act)
        A_CLR: begin
          f_r <= span_t'(f_r + 1'b1);
        end
        A_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            cnt_r <= in_frame_count;
            sf_r  <= in_start_frame;
          end
        end
        A_SETUP1: begin
          f_r    <= span_t'(lo1);
          end_r  <= end1;
          run_r  <= '0;
          pass_r <= 1'b0;
        end
        A_SETUP2: begin
          f_r    <= span_t'(1);
          end_r  <= end2;
          run_r  <= '0;
          pass_r <= 1'b1;
        end
        A_TEST: begin
          run_r <= bit_now ? '0 : run_inc;
          f_r   <= span_t'(f_r + 1'b1);
          if (found_now) begin
            start_r <= start_cand;
          end
        end
        A_RANGE_ALLOC: begin
          a_r   <= start_r;
          e_r   <= alloc_e;
          val_r <= 1'b1;
        end
        A_RANGE_REL: begin
          a_r   <= sf_r;
          e_r   <= rel_e;
          val_r <= 1'b0;
        end
        A_OUT_OK: begin
          out_status_r <= ST_OK;
          if (cmd_r == CMD_ALLOC) begin
            out_first_r <= start_r;
            last_look_r <= start_r;
          end else begin
            out_first_r <= '0;
          end
        end
        A_OUT_FAIL: begin
          out_status_r <= ST_OOM;
          out_first_r  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    flags.clr_more   = f_r[ROW_W-1:0] != row_t'(NUM_ROWS - 1);
    flags.no_item    = !in_valid;
    flags.bad_count  = (cnt_r == '0) || (cnt_r > cnt_t'(MAX_RUN));
    flags.is_release = cmd_r == CMD_RELEASE;
    flags.empty1     = lo1 > frame_limit;
    flags.empty2     = frame_limit == '0;
    flags.found_now  = found_now;
    flags.cont       = (f_r != end_r) && (f_r[BIT_W-1:0] != '1);
    flags.past_end   = f_r > end_r;
    flags.pass2      = pass_r;
    flags.out_busy   = out_valid_r && out_stall;
  end

  assign in_stall        = act != A_IDLE;
  assign out_valid       = out_valid_r;
  assign out_first_frame = out_first_r;
  assign out_status      = out_status_r;

endmodule

// File: src/next_fit_frame_allocator_top.sv
// Channel | Ports                                          | Beat taken when
// in      | in_valid in_stall in_command in_frame_count    | in_valid && !in_stall
//         | in_start_frame                                 |
// out     | out_valid out_stall out_first_frame out_status | out_valid && !out_stall
// cfg     | psel penable pwrite paddr pwdata prdata pready | psel && penable && pwrite
//
// Reset runs a clearing pass over the 64-row bitmap; in_stall stays high meanwhile.
// A release marks its range free; a rejected count goes straight to an out-of-memory result.
// Allocate tests one frame per step, fetching each 64-frame bitmap row before its frames are
// tested, and searches from the last allocated frame up to frame_limit, then from frame 1.
// in_stall is low only while the sequencer waits for a beat; a waiting result does not block it,
// but the next result holds the sequencer until the previous one is taken.
module next_fit_frame_allocator_top
  import nffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [CNT_W-1:0]      in_frame_count,
  input  logic [FRAME_W-1:0]    in_start_frame,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FRAME_W-1:0]    out_first_frame,
  output logic                  out_status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LIMIT_W-1:0] frame_limit_r;
  logic               reg_hit;
  flags_t             flags;
  act_t               act;

  assign reg_hit = paddr[CFG_ADDR_W-1] == REG_FRAME_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      frame_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = reg_hit ? CFG_DATA_W'(frame_limit_r) : '0;
  assign pready = 1'b1;

  nffa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  nffa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .act             (act),
    .flags           (flags),
    .frame_limit     (frame_limit_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_frame_count  (in_frame_count),
    .in_start_frame  (in_start_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_frame (out_first_frame),
    .out_status      (out_status)
  );

endmodule
